@@ hdl/mri_pkg.sv @@
// Package: types, operation codes and helpers for the mixed-radix index unit.
`default_nettype none
package mri_pkg;

  localparam int NDIG   = 8;
  localparam int DIG_W  = 8;
  localparam int RADIX_W = 9;
  localparam int IDX_W  = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] FUNC_TO_LINEAR = 2'd0;
  localparam logic [1:0] FUNC_TO_MULTI  = 2'd1;
  localparam logic [1:0] FUNC_NEXT      = 2'd2;
  localparam logic [1:0] FUNC_NONE      = 2'd3;

  typedef struct packed {
    logic [1:0]       func;
    logic [IDX_W-1:0] linear_index;
    logic [DIG_W-1:0] digit_0;
    logic [DIG_W-1:0] digit_1;
    logic [DIG_W-1:0] digit_2;
    logic [DIG_W-1:0] digit_3;
    logic [DIG_W-1:0] digit_4;
    logic [DIG_W-1:0] digit_5;
    logic [DIG_W-1:0] digit_6;
    logic [DIG_W-1:0] digit_7;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] linear_out;
    logic [DIG_W-1:0] out_digit_0;
    logic [DIG_W-1:0] out_digit_1;
    logic [DIG_W-1:0] out_digit_2;
    logic [DIG_W-1:0] out_digit_3;
    logic [DIG_W-1:0] out_digit_4;
    logic [DIG_W-1:0] out_digit_5;
    logic [DIG_W-1:0] out_digit_6;
    logic [DIG_W-1:0] out_digit_7;
    logic             range_error;
    logic             at_final;
  } out_t;

  typedef logic [NDIG-1:0][DIG_W-1:0]   digits_t;
  typedef logic [NDIG-1:0][RADIX_W-1:0] radices_t;

  // one pipeline beat
  typedef struct packed {
    logic [1:0]       func;
    logic [IDX_W-1:0] w;     // dividend, quotient bits replace consumed bits
    logic [DIG_W-1:0] rem;
    digits_t          din;
    logic [IDX_W-1:0] acc;
    digits_t          odig;
    logic             err;
    logic             fin;
  } stage_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] raw);
    logic [RADIX_W-1:0] r;
    r = raw;
    if (raw == '0) r = RADIX_W'(1);
    else if (raw > RADIX_W'(256)) r = RADIX_W'(256);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/mixed_radix_index_unit.sv @@
// Top level: mixed-radix index unit, config registers and the conversion pipeline.
// Latency: done strobes once a beat has passed the entry register, every stage register and the result register.
// Throughput: one beat per cycle; busy stays low, results cannot be held off.
// The digit split runs eight quotient bits per stage, so depth follows DIGITS.
// Reset clears the pipeline valid bits and sets every radix register to 1.
`default_nettype none
module mixed_radix_index_unit #(
  parameter int DIGITS = 8
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start,
  output logic                                 busy,
  input  mri_pkg::in_t                         in_i,
  output logic                                 done_o,
  output mri_pkg::out_t                        res_o,
  input  wire                                  cfg_we_i,
  input  wire  [mri_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [mri_pkg::RADIX_W-1:0]          cfg_data_i
);

  localparam int NST = DIGITS * 8;
  localparam int LAT = NST + 2;

  logic [mri_pkg::RADIX_W-1:0] radix_q [mri_pkg::NDIG];
  mri_pkg::radices_t rad;
  mri_pkg::stage_t   entry;
  mri_pkg::stage_t   st  [0:NST];
  logic              vld [0:NST];
  mri_pkg::out_t     res_d, res_q;
  logic              done_q;
  logic              acc_beat;

  assign busy     = 1'b0;
  assign acc_beat = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < mri_pkg::NDIG; k++) radix_q[k] <= mri_pkg::RADIX_W'(1);
    end else if (cfg_we_i) begin
      radix_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int k = 0; k < mri_pkg::NDIG; k++) begin
      rad[k] = (k < DIGITS) ? mri_pkg::eff_radix(radix_q[k]) : mri_pkg::RADIX_W'(1);
    end
  end

  // entry: range check of digits and the odometer step
  always_comb begin
    mri_pkg::digits_t d, nd;
    logic ok, found;
    d[0] = in_i.digit_0; d[1] = in_i.digit_1; d[2] = in_i.digit_2; d[3] = in_i.digit_3;
    d[4] = in_i.digit_4; d[5] = in_i.digit_5; d[6] = in_i.digit_6; d[7] = in_i.digit_7;
    ok = 1'b1;
    for (int k = 0; k < mri_pkg::NDIG; k++) begin
      if ({1'b0, d[k]} >= rad[k]) ok = 1'b0;
    end
    found = 1'b0;
    nd    = d;
    for (int k = 0; k < mri_pkg::NDIG; k++) begin
      if (!found) begin
        if ({1'b0, d[k]} + mri_pkg::RADIX_W'(1) < rad[k]) begin
          nd[k] = d[k] + mri_pkg::DIG_W'(1);
          found = 1'b1;
        end else begin
          nd[k] = '0;
        end
      end
    end
    entry      = '0;
    entry.func = in_i.func;
    entry.w    = in_i.linear_index;
    entry.din  = d;
    entry.err  = !ok && (in_i.func == mri_pkg::FUNC_TO_LINEAR ||
                         in_i.func == mri_pkg::FUNC_NEXT);
    if (in_i.func == mri_pkg::FUNC_NEXT) begin
      entry.odig = found ? nd : d;
      entry.fin  = ok && !found;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= acc_beat;
    end
  end

  always_ff @(posedge clk_i) begin
    st[0] <= entry;
  end

  for (genvar j = 0; j < NST; j++) begin : g_stage
    mri_stage #(
      .DIGIT (j / 8),
      .BSEL  (j % 8),
      .PACK  (DIGITS - 1 - j / 8)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .vld_i   (vld[j]),
      .st_i    (st[j]),
      .radix_i (rad),
      .vld_o   (vld[j+1]),
      .st_o    (st[j+1])
    );
  end

  always_comb begin
    mri_pkg::stage_t s;
    logic err;
    s     = st[NST];
    res_d = '0;
    err   = s.err;
    if (s.func == mri_pkg::FUNC_TO_MULTI) err = (s.w != '0);
    if (err) begin
      res_d.range_error = 1'b1;
    end else begin
      unique case (s.func)
        mri_pkg::FUNC_TO_LINEAR: res_d.linear_out = s.acc;
        mri_pkg::FUNC_TO_MULTI, mri_pkg::FUNC_NEXT: begin
          res_d.out_digit_0 = s.odig[0]; res_d.out_digit_1 = s.odig[1];
          res_d.out_digit_2 = s.odig[2]; res_d.out_digit_3 = s.odig[3];
          res_d.out_digit_4 = s.odig[4]; res_d.out_digit_5 = s.odig[5];
          res_d.out_digit_6 = s.odig[6]; res_d.out_digit_7 = s.odig[7];
          res_d.at_final    = s.fin;
        end
        default: res_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_beat |-> ##LAT done_o) else $error("result beat missing");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc_beat, LAT)) else $error("result beat without start");

  a_err_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.range_error && res_o.at_final)) else $error("error with final");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.range_error |-> res_o.linear_out == '0 && res_o.out_digit_0 == '0)
    else $error("error beat carries data");

endmodule
`default_nettype wire

@@ hdl/mri_stage.sv @@
// One pipeline stage: eight quotient bits of a digit split, plus a pack step where BSEL is 0.
`default_nettype none
module mri_stage #(
  parameter int DIGIT = 0,
  parameter int BSEL  = 0,
  parameter int PACK  = 0
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 vld_i,
  input  mri_pkg::stage_t     st_i,
  input  mri_pkg::radices_t   radix_i,
  output logic                vld_o,
  output mri_pkg::stage_t     st_o
);

  mri_pkg::stage_t st_d;

  always_comb begin
    logic [mri_pkg::RADIX_W-1:0] r;
    logic [mri_pkg::RADIX_W-1:0] t;
    logic [mri_pkg::DIG_W-1:0]   rem;
    st_d = st_i;
    r    = radix_i[DIGIT];
    rem  = st_i.rem;
    for (int i = 0; i < 8; i++) begin
      t = {rem, st_i.w[mri_pkg::IDX_W-1-(8*BSEL+i)]};
      if (t >= r) begin
        t = t - r;
        st_d.w[mri_pkg::IDX_W-1-(8*BSEL+i)] = 1'b1;
      end else begin
        st_d.w[mri_pkg::IDX_W-1-(8*BSEL+i)] = 1'b0;
      end
      rem = t[mri_pkg::DIG_W-1:0];
    end
    if (BSEL == 7) begin
      if (st_i.func == mri_pkg::FUNC_TO_MULTI) st_d.odig[DIGIT] = rem;
      rem = '0;
    end
    st_d.rem = rem;
    if (BSEL == 0) begin
      st_d.acc = mri_pkg::IDX_W'(st_i.acc * {{(mri_pkg::IDX_W-mri_pkg::RADIX_W){1'b0}},
                                              radix_i[PACK]})
               + {{(mri_pkg::IDX_W-mri_pkg::DIG_W){1'b0}}, st_i.din[PACK]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_o <= st_d;
  end

endmodule
`default_nettype wire

@@ verif/mixed_radix_index_unit_tb.sv @@
// Testbench for the mixed-radix index unit: directed and random beats checked against a predictor.
`timescale 1ns / 1ps
module mixed_radix_index_unit_tb;
  import mri_pkg::*;

  localparam int LAT = 8 * 8 + 2;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_i = '0;
  logic done_o;
  out_t res_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [RADIX_W-1:0] cfg_data_i = '0;

  logic [RADIX_W-1:0] radix_shadow [NDIG];
  out_t conv_q[$];
  int mismatches = 0;
  int beats_sent = 0;
  int beats_seen = 0;
  int finals_seen = 0;
  int errors_seen = 0;

  always #5 clk_i = ~clk_i;

  mixed_radix_index_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .done_o(done_o), .res_o(res_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  function automatic logic [63:0] radix_of(int k);
    logic [RADIX_W-1:0] r;
    r = radix_shadow[k];
    if (r == 0) return 64'd1;
    if (r > 256) return 64'd256;
    return 64'(r);
  endfunction

  function automatic digits_t digits_of(in_t b);
    digits_t d;
    d[0] = b.digit_0; d[1] = b.digit_1; d[2] = b.digit_2; d[3] = b.digit_3;
    d[4] = b.digit_4; d[5] = b.digit_5; d[6] = b.digit_6; d[7] = b.digit_7;
    return d;
  endfunction

  function automatic out_t convert(in_t b);
    out_t o;
    digits_t d;
    logic [63:0] x;
    logic [63:0] acc;
    logic ok;
    logic moved;
    o = '0;
    d = digits_of(b);
    ok = 1'b1;
    for (int k = 0; k < NDIG; k++) if (64'(d[k]) >= radix_of(k)) ok = 1'b0;
    if (b.func == FUNC_TO_LINEAR) begin
      if (!ok) begin
        o.range_error = 1'b1;
        return o;
      end
      acc = 0;
      for (int k = NDIG - 1; k >= 0; k--) acc = acc * radix_of(k) + 64'(d[k]);
      o.linear_out = acc;
      return o;
    end
    if (b.func == FUNC_TO_MULTI) begin
      x = b.linear_index;
      for (int k = 0; k < NDIG; k++) begin
        d[k] = 8'(x % radix_of(k));
        x = x / radix_of(k);
      end
      if (x != 0) begin
        o.range_error = 1'b1;
        return o;
      end
    end else if (b.func == FUNC_NEXT) begin
      if (!ok) begin
        o.range_error = 1'b1;
        return o;
      end
      moved = 1'b0;
      for (int k = 0; k < NDIG; k++) begin
        if (!moved && 64'(d[k]) + 1 < radix_of(k)) begin
          d[k] = d[k] + 8'd1;
          for (int j = 0; j < k; j++) d[j] = '0;
          moved = 1'b1;
        end
      end
      o.at_final = !moved;
    end else begin
      return o;
    end
    o.out_digit_0 = d[0]; o.out_digit_1 = d[1]; o.out_digit_2 = d[2];
    o.out_digit_3 = d[3]; o.out_digit_4 = d[4]; o.out_digit_5 = d[5];
    o.out_digit_6 = d[6]; o.out_digit_7 = d[7];
    return o;
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && done_o) begin
      beats_seen++;
      if (conv_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", res_o);
      end else begin
        want = conv_q.pop_front();
        if (res_o.range_error) errors_seen++;
        if (res_o.at_final) finals_seen++;
        if (res_o.linear_out !== want.linear_out || res_o.out_digit_0 !== want.out_digit_0 ||
            res_o.out_digit_1 !== want.out_digit_1 || res_o.out_digit_2 !== want.out_digit_2 ||
            res_o.out_digit_3 !== want.out_digit_3 || res_o.out_digit_4 !== want.out_digit_4 ||
            res_o.out_digit_5 !== want.out_digit_5 || res_o.out_digit_6 !== want.out_digit_6 ||
            res_o.out_digit_7 !== want.out_digit_7 ||
            res_o.range_error !== want.range_error || res_o.at_final !== want.at_final) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", want, res_o);
        end
      end
    end
  end

  // start stays high after a beat so that a zero gap gives back-to-back beats
  task automatic send_beat(in_t b, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i <= b;
    conv_q = {conv_q, convert(b)};
    beats_sent++;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (conv_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_radix(int k, logic [RADIX_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_IDX_W'(k);
    cfg_data_i <= v;
    radix_shadow[k] = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_t tuple_beat(logic [1:0] f, digits_t d);
    in_t b;
    b = '0;
    b.func = f;
    b.linear_index = {$urandom, $urandom};
    b.digit_0 = d[0]; b.digit_1 = d[1]; b.digit_2 = d[2]; b.digit_3 = d[3];
    b.digit_4 = d[4]; b.digit_5 = d[5]; b.digit_6 = d[6]; b.digit_7 = d[7];
    return b;
  endfunction

  function automatic digits_t valid_digits(bit top);
    digits_t d;
    for (int k = 0; k < NDIG; k++)
      d[k] = (top && $urandom_range(0, 1)) ? 8'(radix_of(k) - 1)
                                           : 8'($urandom_range(0, int'(radix_of(k)) - 1));
    return d;
  endfunction

  function automatic logic [63:0] radix_product();
    logic [63:0] p;
    p = 1;
    for (int k = 0; k < NDIG; k++) p = p * radix_of(k);
    return p;
  endfunction

  task automatic test_reset_radices();
    digits_t d;
    in_t b;
    d = '0;
    send_beat(tuple_beat(FUNC_TO_LINEAR, d), 0);
    send_beat(tuple_beat(FUNC_NEXT, d), 0);
    b = tuple_beat(FUNC_TO_MULTI, d);
    b.linear_index = 0;
    send_beat(b, 0);
    b.linear_index = 1;
    send_beat(b, 0);
    d[3] = 8'd1;
    send_beat(tuple_beat(FUNC_TO_LINEAR, d), 0);
    send_beat(tuple_beat(FUNC_NONE, '1), 0);
    drain();
  endtask

  task automatic test_full_radices();
    digits_t d;
    in_t b;
    for (int k = 0; k < NDIG; k++) write_radix(k, (k % 2) ? 9'd256 : 9'h1FF);
    d = '1;
    send_beat(tuple_beat(FUNC_TO_LINEAR, d), 0);
    send_beat(tuple_beat(FUNC_NEXT, d), 0);
    b = tuple_beat(FUNC_TO_MULTI, d);
    b.linear_index = '1;
    send_beat(b, 0);
    b.linear_index = 64'h0123_4567_89AB_CDEF;
    send_beat(b, 0);
    b.linear_index = 0;
    send_beat(b, 0);
    d = '0;
    send_beat(tuple_beat(FUNC_TO_LINEAR, d), 0);
    d[0] = 8'd255; d[1] = 8'd17;
    send_beat(tuple_beat(FUNC_NEXT, d), 0);
    drain();
  endtask

  task automatic test_small_radices();
    digits_t d;
    in_t b;
    write_radix(0, 9'd0);
    write_radix(1, 9'd3);
    write_radix(2, 9'd5);
    write_radix(3, 9'd256);
    for (int k = 4; k < NDIG; k++) write_radix(k, 9'd1);
    d = '0; d[0] = 8'd0; d[1] = 8'd2; d[2] = 8'd4; d[3] = 8'd255;
    send_beat(tuple_beat(FUNC_NEXT, d), 0);
    send_beat(tuple_beat(FUNC_TO_LINEAR, d), 0);
    d[2] = 8'd5;
    send_beat(tuple_beat(FUNC_NEXT, d), 0);
    d[2] = 8'd1; d[7] = 8'd1;
    send_beat(tuple_beat(FUNC_TO_LINEAR, d), 0);
    b = tuple_beat(FUNC_TO_MULTI, d);
    b.linear_index = radix_product();
    send_beat(b, 0);
    b.linear_index = radix_product() - 1;
    send_beat(b, 0);
    drain();
  endtask

  task automatic test_random_configs(int n);
    in_t b;
    int pick;
    for (int phase = 0; phase < 10; phase++) begin
      for (int k = 0; k < NDIG; k++) begin
        pick = $urandom_range(0, 9);
        write_radix(k, pick == 0 ? 9'(256 + $urandom_range(0, 255)) :
                       pick == 1 ? 9'd1 : 9'($urandom_range(1, 12)));
      end
      for (int i = 0; i < n / 10; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 6) b = tuple_beat(FUNC_TO_LINEAR, valid_digits(0));
        else if (pick < 12) b = tuple_beat(FUNC_NEXT, valid_digits(pick > 9));
        else if (pick < 17) begin
          b = tuple_beat(FUNC_TO_MULTI, valid_digits(0));
          b.linear_index = {$urandom, $urandom} % (radix_product() + (pick == 16));
          if (pick == 16) b.linear_index = b.linear_index + 1;
        end else begin
          b = tuple_beat(2'($urandom_range(0, 3)), digits_t'({$urandom, $urandom}));
          if ($urandom_range(0, 1)) b.linear_index = radix_product() + $urandom_range(0, 3);
        end
        send_beat(b, $urandom_range(0, 2) != 0);
      end
      drain();
      repeat (LAT) @(posedge clk_i);
    end
  endtask

  initial begin
    for (int k = 0; k < NDIG; k++) radix_shadow[k] = 9'd1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_radices();
    test_full_radices();
    test_small_radices();
    test_random_configs(480);
    drain();
    repeat (LAT + 10) @(posedge clk_i);
    $display("sent %0d beats, checked %0d results (%0d range errors, %0d final tuples)",
             beats_sent, beats_seen, errors_seen, finals_seen);
    if (mismatches == 0 && conv_q.size() == 0) begin
      $display("mixed_radix_index_unit: match");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, conv_q.size());
      $display("mixed_radix_index_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("mixed_radix_index_unit: mismatch");
    $finish;
  end

endmodule
